// ===== hdl/ste_pkg.sv =====
// Shared constants, codes and control types of the semaphore table engine.
package ste_pkg;

   localparam int KIND_W   = 3;
   localparam int SID_W    = 4;
   localparam int TID_W    = 8;
   localparam int CNT_W    = 16;
   localparam int STATUS_W = 3;
   localparam int ACT_W    = 2;

   localparam int DEF_NUM_SEMS       = 16;
   localparam int DEF_QUEUE_DEPTH    = 16;
   localparam int DEF_THREAD_ID_BITS = 8;

   // Upper bound on the slots that a create may hand out, set by the width of sem_id.
   localparam int ADDR_LIMIT = 1 << SID_W;

   localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;

   localparam logic [KIND_W-1:0] KIND_CREATE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WAIT   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SIGNAL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_ID     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_USED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NEG_INIT   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd5;

   localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_BLOCK = 2'd1;
   localparam logic [ACT_W-1:0] ACT_WAKE  = 2'd2;

   typedef struct packed {
      logic accept;
      logic exec;
      logic wake;
   } ste_cmd_type;

   typedef struct packed {
      logic kind_ok;
      logic out_free;
      logic need_wake;
      logic wake_last;
   } ste_stat_type;

endpackage

// ===== hdl/ste_channels.sv =====
// Request and response channel interfaces of the semaphore table engine.
interface sem_req_if import ste_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       kind;
   logic [SID_W-1:0]        sem_id;
   logic [TID_W-1:0]        thread_id;
   logic signed [CNT_W-1:0] start_count;

   modport source (output valid, kind, sem_id, thread_id, start_count, input ready);
   modport sink (input valid, kind, sem_id, thread_id, start_count, output ready);
endinterface

interface sem_rsp_if import ste_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic [SID_W-1:0]        sem_out;
   logic signed [CNT_W-1:0] count_out;
   logic [ACT_W-1:0]        action;
   logic [TID_W-1:0]        thread_out;
   logic                    last;

   modport source (output valid, status, sem_out, count_out, action, thread_out, last,
                   input ready);
   modport sink (input valid, status, sem_out, count_out, action, thread_out, last,
                 output ready);
endinterface

// ===== hdl/ste_ctrl.sv =====
// Controller state machine that sequences accept, execute and wake steps.
module ste_ctrl import ste_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ste_stat_type stat,
   output ste_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_WAKE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.exec   = 1'b0;
      cmd.wake   = 1'b0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.kind_ok) begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = stat.need_wake ? S_WAKE : S_IDLE;
            end
         end
         S_WAKE: begin
            if (stat.out_free) begin
               cmd.wake = 1'b1;
               if (stat.wake_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/ste_dpath.sv =====
// Datapath with the slot table, the wait queue store and the response register.
module ste_dpath import ste_pkg::*; #(
   parameter int NUM_SEMS       = DEF_NUM_SEMS,
   parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
   parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ste_cmd_type             cmd,
   output ste_stat_type            stat,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic [SID_W-1:0]        req_sem_id,
   input  logic [TID_W-1:0]        req_thread_id,
   input  logic signed [CNT_W-1:0] req_start_count,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [SID_W-1:0]        rsp_sem_out,
   output logic signed [CNT_W-1:0] rsp_count_out,
   output logic [ACT_W-1:0]        rsp_action,
   output logic [TID_W-1:0]        rsp_thread_out,
   output logic                    rsp_last
);

   localparam int SEM_BITS   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int QB         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FB         = $clog2(QUEUE_DEPTH + 1);
   localparam int REC_W      = CNT_W + QB + FB;
   localparam int WDEPTH     = NUM_SEMS * (1 << QB);
   localparam int ADDR_SLOTS = (NUM_SEMS < ADDR_LIMIT) ? NUM_SEMS : ADDR_LIMIT;

   function automatic logic [QB-1:0] next_head(input logic [QB-1:0] h);
      logic [QB-1:0] r;
      r = (h == QB'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
      return r;
   endfunction

   logic [REC_W-1:0]          rec_mem [NUM_SEMS];
   logic [THREAD_ID_BITS-1:0] wait_mem [WDEPTH];

   logic [KIND_W-1:0]         kind_ff;
   logic [SID_W-1:0]          sid_ff;
   logic [TID_W-1:0]          tid_ff;
   logic signed [CNT_W-1:0]   init_ff;
   logic [SEM_BITS-1:0]       slot_ff, slot_in;
   logic [STATUS_W-1:0]       pre_status_ff, pre_status_in;
   logic signed [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [QB-1:0]             head_ff, head_in;
   logic [FB-1:0]             fill_ff, fill_in;
   logic [NUM_SEMS-1:0]       slot_used_ff, slot_used_in;
   logic [REC_W-1:0]          rec_q_ff;
   logic [THREAD_ID_BITS-1:0] wrd_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [SID_W-1:0]          rsp_sem_ff, rsp_sem_in;
   logic signed [CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [ACT_W-1:0]          rsp_action_ff, rsp_action_in;
   logic [TID_W-1:0]          rsp_thread_ff, rsp_thread_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      free_found;
   logic [SEM_BITS-1:0]       free_idx;
   logic                      bad_id;
   logic [SEM_BITS-1:0]       req_slot;

   logic signed [CNT_W-1:0]   rc, cnt_dec, cnt_inc;
   logic [QB-1:0]             rh, tail;
   logic [FB-1:0]             rf;
   logic [FB:0]               tail_sum;
   logic                      wait_blocks, q_full, sig_pop, wake_last;
   logic                      rec_we, wait_we, out_load;
   logic [REC_W-1:0]          rec_wdata;
   logic [TID_W-1:0]          tid_kept;

   // Lowest free slot among those reachable by the request's slot field.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = ADDR_SLOTS - 1; i >= 0; i--) begin
         if (!slot_used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SEM_BITS'(i);
         end
      end
   end

   assign bad_id   = 32'(req_sem_id) >= NUM_SEMS;
   assign req_slot = SEM_BITS'(req_sem_id);

   always_comb begin
      if (req_kind == KIND_CREATE) begin
         pre_status_in = req_start_count[CNT_W-1] ? ST_NEG_INIT :
                         (free_found ? ST_OK : ST_NO_SLOT);
      end else if (bad_id) begin
         pre_status_in = ST_BAD_ID;
      end else begin
         pre_status_in = slot_used_ff[req_slot] ? ST_OK : ST_NOT_USED;
      end
   end

   assign rc       = signed'(rec_q_ff[REC_W-1 -: CNT_W]);
   assign rh       = rec_q_ff[FB +: QB];
   assign rf       = rec_q_ff[FB-1:0];
   assign cnt_dec  = rc - 16'sd1;
   assign cnt_inc  = (rc == CNT_MAX) ? rc : rc + 16'sd1;
   assign wait_blocks = rc[CNT_W-1] || (rc == '0);
   assign q_full   = rf >= FB'(QUEUE_DEPTH);
   assign sig_pop  = (cnt_inc[CNT_W-1] || (cnt_inc == '0)) && (rf != '0);
   assign tail_sum = (FB+1)'(rh) + (FB+1)'(rf);
   assign tail     = (tail_sum >= (FB+1)'(QUEUE_DEPTH)) ?
                     QB'(tail_sum - (FB+1)'(QUEUE_DEPTH)) : QB'(tail_sum);
   assign tid_kept = TID_W'(THREAD_ID_BITS'(tid_ff));
   assign wake_last = (kind_ff == KIND_SIGNAL) || (fill_ff == FB'(1));

   assign stat.kind_ok   = req_kind <= KIND_READ;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign stat.need_wake = (pre_status_ff == ST_OK) &&
                           (((kind_ff == KIND_SIGNAL) && sig_pop) ||
                            ((kind_ff == KIND_DELETE) && (rf != '0)));
   assign stat.wake_last = wake_last;

   always_comb begin
      slot_in       = cmd.accept ? ((req_kind == KIND_CREATE) ? free_idx : req_slot)
                                 : slot_ff;
      cnt_in        = cnt_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      slot_used_in  = slot_used_ff;
      rec_we        = 1'b0;
      rec_wdata     = rec_q_ff;
      wait_we       = 1'b0;
      out_load      = 1'b0;
      rsp_status_in = pre_status_ff;
      rsp_sem_in    = sid_ff;
      rsp_count_in  = '0;
      rsp_action_in = ACT_NONE;
      rsp_thread_in = '0;
      rsp_last_in   = 1'b1;

      if (cmd.exec) begin
         cnt_in   = (kind_ff == KIND_SIGNAL) ? cnt_inc : rc;
         head_in  = rh;
         fill_in  = rf;
         out_load = !stat.need_wake;
         if (kind_ff == KIND_CREATE) begin
            rsp_sem_in = (pre_status_ff == ST_OK) ? SID_W'(slot_ff) : '0;
         end
         if (pre_status_ff == ST_OK) begin
            case (kind_ff)
               KIND_CREATE: begin
                  slot_used_in[slot_ff] = 1'b1;
                  rec_we       = 1'b1;
                  rec_wdata    = {init_ff, {QB{1'b0}}, {FB{1'b0}}};
                  rsp_count_in = init_ff;
               end
               KIND_WAIT: begin
                  if (wait_blocks && q_full) begin
                     rsp_status_in = ST_QUEUE_FULL;
                     rsp_count_in  = rc;
                  end else if (wait_blocks) begin
                     wait_we       = 1'b1;
                     rec_we        = 1'b1;
                     rec_wdata     = {cnt_dec, rh, rf + 1'b1};
                     rsp_count_in  = cnt_dec;
                     rsp_action_in = ACT_BLOCK;
                     rsp_thread_in = tid_kept;
                  end else begin
                     rec_we       = 1'b1;
                     rec_wdata    = {cnt_dec, rh, rf};
                     rsp_count_in = cnt_dec;
                  end
               end
               KIND_SIGNAL: begin
                  rec_we       = 1'b1;
                  rec_wdata    = sig_pop ? {cnt_inc, next_head(rh), rf - 1'b1}
                                         : {cnt_inc, rh, rf};
                  rsp_count_in = cnt_inc;
               end
               KIND_DELETE: begin
                  slot_used_in[slot_ff] = 1'b0;
                  rsp_count_in = rc;
               end
               default: begin
                  rsp_count_in = rc;
               end
            endcase
         end
      end else if (cmd.wake) begin
         out_load      = 1'b1;
         head_in       = next_head(head_ff);
         fill_in       = fill_ff - 1'b1;
         rsp_status_in = ST_OK;
         rsp_count_in  = cnt_ff;
         rsp_action_in = ACT_WAKE;
         rsp_thread_in = TID_W'(wrd_ff);
         rsp_last_in   = wake_last;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_used_ff <= slot_used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff       <= req_kind;
         sid_ff        <= req_sem_id;
         tid_ff        <= req_thread_id;
         init_ff       <= req_start_count;
         pre_status_ff <= pre_status_in;
      end
      slot_ff <= slot_in;
      cnt_ff  <= cnt_in;
      head_ff <= head_in;
      fill_ff <= fill_in;
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_sem_ff    <= rsp_sem_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_action_ff <= rsp_action_in;
         rsp_thread_ff <= rsp_thread_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // The slot record and the queue entry at the head are read every cycle.
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[slot_ff] <= rec_wdata;
      end
      rec_q_ff <= rec_mem[slot_in];
   end

   always_ff @(posedge clock) begin
      if (wait_we) begin
         wait_mem[{slot_ff, tail}] <= THREAD_ID_BITS'(tid_ff);
      end
      wrd_ff <= wait_mem[{slot_in, head_in}];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_sem_out    = rsp_sem_ff;
   assign rsp_count_out  = rsp_count_ff;
   assign rsp_action     = rsp_action_ff;
   assign rsp_thread_out = rsp_thread_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== hdl/semaphore_table_engine.sv =====
// Top level of the semaphore table engine: controller and datapath.
//
//   Channel   Direction  Signals                                        Word
//   req_bus   in         valid ready kind sem_id thread_id start_count  one request
//   rsp_bus   out        valid ready status sem_out count_out action    one result
//                        thread_out last
//
// A request has two steps: accept and slot record read, then execute.
// A signal that wakes a thread adds a wake step; a delete with waiters adds
// a wake step per woken thread, set by the single queue read port.
// Requests of an unknown kind are accepted and give no word.
// Reset clears the slot use flags, the controller state and the result valid flag;
// no clearing pass runs.
// A stalled result holds in the output register; execute and wake steps wait until it is taken.
module semaphore_table_engine import ste_pkg::*; #(
   parameter int NUM_SEMS       = DEF_NUM_SEMS,
   parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
   parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS
) (
   input logic       clock,
   input logic       reset,
   sem_req_if.sink   req_bus,
   sem_rsp_if.source rsp_bus
);

   ste_cmd_type  cmd;
   ste_stat_type stat;

   ste_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ste_dpath #(
      .NUM_SEMS       (NUM_SEMS),
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .THREAD_ID_BITS (THREAD_ID_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_kind        (req_bus.kind),
      .req_sem_id      (req_bus.sem_id),
      .req_thread_id   (req_bus.thread_id),
      .req_start_count (req_bus.start_count),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_status      (rsp_bus.status),
      .rsp_sem_out     (rsp_bus.sem_out),
      .rsp_count_out   (rsp_bus.count_out),
      .rsp_action      (rsp_bus.action),
      .rsp_thread_out  (rsp_bus.thread_out),
      .rsp_last        (rsp_bus.last)
   );

endmodule

// ===== hdl/ste_checker.sv =====
// Port level assertions for the semaphore table engine and their binding.
module ste_checker import ste_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [KIND_W-1:0]       req_kind,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [STATUS_W-1:0]     rsp_status,
   input logic signed [CNT_W-1:0] rsp_count_out,
   input logic [ACT_W-1:0]        rsp_action,
   input logic [TID_W-1:0]        rsp_thread_out,
   input logic                    rsp_last
);

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_count_out) && $stable(rsp_thread_out)
                                  && $stable(rsp_last))
      else $error("stalled result word changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind <= KIND_READ) |=> !req_ready)
      else $error("request taken while the previous one is still executing");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         rsp_last && (rsp_action == ACT_NONE) && (rsp_thread_out == '0))
      else $error("error word is not a single plain result");

   a_drain_continuous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a wake sequence");

endmodule

bind semaphore_table_engine ste_checker u_ste_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_kind       (req_bus.kind),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_count_out  (rsp_bus.count_out),
   .rsp_action     (rsp_bus.action),
   .rsp_thread_out (rsp_bus.thread_out),
   .rsp_last       (rsp_bus.last)
);

// ===== sim/tb.sv =====
// Self-checking testbench of the semaphore table engine with a built-in predictor.
`timescale 1ns / 100ps

module tb;
   import ste_pkg::*;

   localparam int NSEM        = DEF_NUM_SEMS;
   localparam int QDEPTH      = DEF_QUEUE_DEPTH;
   localparam int CREATE_SPAN = (NSEM < ADDR_LIMIT) ? NSEM : ADDR_LIMIT;
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 40;
   localparam int ITEM_TARGET = 420;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [SID_W-1:0]        sem_id;
      logic [TID_W-1:0]        thread_id;
      logic signed [CNT_W-1:0] start_count;
      logic                    drain;
   } sem_call_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [SID_W-1:0]        sem;
      logic signed [CNT_W-1:0] count;
      logic [ACT_W-1:0]        action;
      logic [TID_W-1:0]        thread;
      logic                    last;
   } sem_reply_type;

   logic clock;
   logic reset;

   sem_req_if req_ch ();
   sem_rsp_if rsp_ch ();

   semaphore_table_engine u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch.sink),
      .rsp_bus (rsp_ch.source)
   );

   sem_call_type  queued_calls[$];
   sem_reply_type predicted_replies[$];
   sem_call_type  call_on_bus;

   bit        tbl_used[NSEM];
   int        tbl_count[NSEM];
   bit [7:0]  tbl_waiters[NSEM][QDEPTH];
   int        tbl_head[NSEM];
   int        tbl_fill[NSEM];

   bit plan_used[CREATE_SPAN];
   int plan_last_slot;
   int real_items;

   int calls_sent;
   int replies_seen;
   int fail_count;
   int stall_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic sem_reply_type make_reply(logic [STATUS_W-1:0] st, int sem, int cnt,
                                                logic [ACT_W-1:0] act, int thr, bit lst);
      sem_reply_type r;
      r.status = st;
      r.sem    = sem[SID_W-1:0];
      r.count  = cnt[CNT_W-1:0];
      r.action = act;
      r.thread = thr[TID_W-1:0];
      r.last   = lst;
      return r;
   endfunction

   function automatic int pop_waiter(int s);
      int t;
      t = tbl_waiters[s][tbl_head[s]];
      tbl_head[s] = (tbl_head[s] + 1) % QDEPTH;
      tbl_fill[s] = tbl_fill[s] - 1;
      return t;
   endfunction

   task automatic apply_call(input sem_call_type c);
      int s;
      int cnt;
      int init;
      int t;
      bit found;
      s = c.sem_id;
      init = $signed(c.start_count);
      found = 1'b0;
      if (c.kind == KIND_CREATE) begin
         if (init < 0) begin
            predicted_replies.push_back(make_reply(ST_NEG_INIT, 0, 0, ACT_NONE, 0, 1'b1));
         end else begin
            for (int i = 0; i < CREATE_SPAN; i++) begin
               if (!found && !tbl_used[i]) begin
                  found = 1'b1;
                  tbl_used[i] = 1'b1;
                  tbl_count[i] = init;
                  tbl_head[i] = 0;
                  tbl_fill[i] = 0;
                  predicted_replies.push_back(make_reply(ST_OK, i, init, ACT_NONE, 0, 1'b1));
               end
            end
            if (!found)
               predicted_replies.push_back(make_reply(ST_NO_SLOT, 0, 0, ACT_NONE, 0, 1'b1));
         end
      end else if (c.kind > KIND_READ) begin
         // Unknown kinds leave the table alone and produce no word.
      end else if (s >= NSEM) begin
         predicted_replies.push_back(make_reply(ST_BAD_ID, s, 0, ACT_NONE, 0, 1'b1));
      end else if (!tbl_used[s]) begin
         predicted_replies.push_back(make_reply(ST_NOT_USED, s, 0, ACT_NONE, 0, 1'b1));
      end else if (c.kind == KIND_WAIT) begin
         cnt = tbl_count[s];
         if (cnt - 1 < 0) begin
            if (tbl_fill[s] >= QDEPTH) begin
               predicted_replies.push_back(make_reply(ST_QUEUE_FULL, s, cnt, ACT_NONE, 0,
                                                      1'b1));
            end else begin
               tbl_waiters[s][(tbl_head[s] + tbl_fill[s]) % QDEPTH] = c.thread_id;
               tbl_fill[s] = tbl_fill[s] + 1;
               tbl_count[s] = cnt - 1;
               predicted_replies.push_back(make_reply(ST_OK, s, cnt - 1, ACT_BLOCK,
                                                      c.thread_id, 1'b1));
            end
         end else begin
            tbl_count[s] = cnt - 1;
            predicted_replies.push_back(make_reply(ST_OK, s, cnt - 1, ACT_NONE, 0, 1'b1));
         end
      end else if (c.kind == KIND_SIGNAL) begin
         cnt = tbl_count[s];
         if (cnt < 32767)
            cnt = cnt + 1;
         tbl_count[s] = cnt;
         if (cnt <= 0 && tbl_fill[s] > 0) begin
            t = pop_waiter(s);
            predicted_replies.push_back(make_reply(ST_OK, s, cnt, ACT_WAKE, t, 1'b1));
         end else begin
            predicted_replies.push_back(make_reply(ST_OK, s, cnt, ACT_NONE, 0, 1'b1));
         end
      end else if (c.kind == KIND_DELETE) begin
         cnt = tbl_count[s];
         tbl_used[s] = 1'b0;
         if (tbl_fill[s] == 0) begin
            predicted_replies.push_back(make_reply(ST_OK, s, cnt, ACT_NONE, 0, 1'b1));
         end else begin
            while (tbl_fill[s] > 0) begin
               t = pop_waiter(s);
               predicted_replies.push_back(make_reply(ST_OK, s, cnt, ACT_WAKE, t,
                                                      tbl_fill[s] == 0));
            end
            tbl_head[s] = 0;
         end
      end else begin
         predicted_replies.push_back(make_reply(ST_OK, s, tbl_count[s], ACT_NONE, 0, 1'b1));
      end
   endtask

   // Queues one call and tracks slot ownership so that later calls can aim at live slots.
   task automatic add_call(input logic [KIND_W-1:0] kind, input int sid, input int tid,
                           input int init);
      sem_call_type c;
      c.kind = kind;
      c.sem_id = sid[SID_W-1:0];
      c.thread_id = tid[TID_W-1:0];
      c.start_count = init[CNT_W-1:0];
      c.drain = 1'b0;
      queued_calls.push_back(c);
      plan_last_slot = -1;
      if (kind <= KIND_READ)
         real_items++;
      if (kind == KIND_CREATE && init >= 0) begin
         for (int i = 0; i < CREATE_SPAN; i++) begin
            if (plan_last_slot < 0 && !plan_used[i]) begin
               plan_used[i] = 1'b1;
               plan_last_slot = i;
            end
         end
      end else if (kind == KIND_DELETE && sid < CREATE_SPAN) begin
         plan_used[sid] = 1'b0;
      end
   endtask

   task automatic add_drain();
      sem_call_type c;
      c = '0;
      c.drain = 1'b1;
      queued_calls.push_back(c);
   endtask

   function automatic int pick_slot();
      int live[$];
      for (int i = 0; i < CREATE_SPAN; i++)
         if (plan_used[i])
            live.push_back(i);
      if (live.size() != 0 && $urandom_range(0, 99) < 80)
         return live[$urandom_range(0, live.size() - 1)];
      return $urandom_range(0, (1 << SID_W) - 1);
   endfunction

   function automatic int pick_init();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(0, 3);
      if (r < 80)
         return -int'($urandom_range(1, 32768));
      if (r < 90)
         return $signed(16'($urandom()));
      return 32766 + $urandom_range(0, 1);
   endfunction

   task automatic build_stimulus();
      int r;
      int slot;
      int n;
      add_call(KIND_CREATE, 0, 0, -1);
      add_call(KIND_CREATE, 0, 0, -32768);
      add_call(KIND_CREATE, 0, 8'hA5, 32767);
      add_call(KIND_SIGNAL, 0, 0, 0);
      add_call(KIND_WAIT, 0, 8'h55, 0);
      add_call(KIND_READ, 0, 0, 0);
      add_call(KIND_WAIT, 5, 8'h12, 0);
      add_call(KIND_SIGNAL, 5, 0, 0);
      add_call(KIND_DELETE, 5, 0, 0);
      add_call(KIND_READ, 5, 0, 0);
      add_call(KIND_CREATE, 0, 0, 0);
      add_call(KIND_WAIT, 1, 8'hFF, 0);
      add_call(KIND_WAIT, 1, 8'h00, 0);
      add_call(KIND_READ, 1, 0, 0);
      add_call(KIND_SIGNAL, 1, 0, 0);
      add_call(KIND_DELETE, 1, 0, 0);
      add_call(KIND_CREATE, 15, 8'hFF, 0);
      add_call(KIND_DELETE, 1, 0, 0);
      add_call(3'd5, 0, 0, 0);
      add_call(3'd6, 0, 0, 0);
      add_call(3'd7, 0, 0, 0);
      add_call(KIND_DELETE, 0, 0, 0);
      add_drain();
      while (real_items < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            // Fill one wait queue past its depth, then delete the slot or signal it.
            add_call(KIND_CREATE, pick_slot(), $urandom_range(0, 255), 0);
            slot = plan_last_slot;
            if (slot >= 0) begin
               n = QDEPTH + 1 + $urandom_range(0, 2);
               for (int i = 0; i < n; i++)
                  add_call(KIND_WAIT, slot, $urandom_range(0, 255), 0);
               if ($urandom_range(0, 99) < 60) begin
                  add_call(KIND_DELETE, slot, 0, 0);
               end else begin
                  n = $urandom_range(1, 4);
                  for (int i = 0; i < n; i++)
                     add_call(KIND_SIGNAL, slot, 0, 0);
               end
            end
         end else if (r < 5) begin
            // Use up every slot, hit the full table, then free some again.
            while (plan_used.sum() with (int'(item)) < CREATE_SPAN)
               add_call(KIND_CREATE, pick_slot(), $urandom_range(0, 255),
                        $urandom_range(0, 2));
            add_call(KIND_CREATE, pick_slot(), $urandom_range(0, 255), $urandom_range(0, 5));
            n = $urandom_range(4, 12);
            for (int i = 0; i < n; i++)
               add_call(KIND_DELETE, $urandom_range(0, CREATE_SPAN - 1), 0, 0);
         end else if (r < 6) begin
            add_drain();
         end else begin
            r = $urandom_range(0, 99);
            if (r < 12)
               add_call(KIND_CREATE, pick_slot(), $urandom_range(0, 255), pick_init());
            else if (r < 42)
               add_call(KIND_WAIT, pick_slot(), $urandom_range(0, 255), pick_init());
            else if (r < 70)
               add_call(KIND_SIGNAL, pick_slot(), $urandom_range(0, 255), pick_init());
            else if (r < 80)
               add_call(KIND_DELETE, pick_slot(), $urandom_range(0, 255), pick_init());
            else if (r < 94)
               add_call(KIND_READ, pick_slot(), $urandom_range(0, 255), pick_init());
            else
               add_call(3'($urandom_range(5, 7)), pick_slot(), $urandom_range(0, 255),
                        pick_init());
         end
         if (real_items == ITEM_TARGET / 2)
            add_drain();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_call(call_on_bus);
            calls_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (queued_calls.size() != 0 && queued_calls[0].drain &&
                predicted_replies.size() == 0)
               void'(queued_calls.pop_front());
            if (queued_calls.size() != 0 && !queued_calls[0].drain &&
                ((calls_sent >= 150 && calls_sent < 250) || $urandom_range(0, 99) >= 32)) begin
               call_on_bus = queued_calls.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.kind        <= call_on_bus.kind;
               req_ch.sem_id      <= call_on_bus.sem_id;
               req_ch.thread_id   <= call_on_bus.thread_id;
               req_ch.start_count <= call_on_bus.start_count;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      sem_reply_type seen;
      sem_reply_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.status = rsp_ch.status;
            seen.sem    = rsp_ch.sem_out;
            seen.count  = rsp_ch.count_out;
            seen.action = rsp_ch.action;
            seen.thread = rsp_ch.thread_out;
            seen.last   = rsp_ch.last;
            if (predicted_replies.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("Unexpected word %0d: status=%0d sem=%0d count=%0d %s%0d %s%0d %s%0d",
                           replies_seen, seen.status, seen.sem, seen.count,
                           "action=", seen.action, "thread=", seen.thread,
                           "last=", seen.last);
            end else begin
               want = predicted_replies.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("Word %0d mismatch: expected status=%0d sem=%0d count=%0d %s%0d %s%0d %s%0d",
                              replies_seen, want.status, want.sem, want.count,
                              "action=", want.action, "thread=", want.thread,
                              "last=", want.last);
                     $display("   got status=%0d sem=%0d count=%0d action=%0d %s%0d %s%0d",
                              seen.status, seen.sem, seen.count, seen.action,
                              "thread=", seen.thread, "last=", seen.last);
                  end
               end
            end
            replies_seen++;
         end
         rsp_ch.ready <= (replies_seen >= 150 && replies_seen < 250) ||
                         ($urandom_range(0, 99) >= 32);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = '0;
      req_ch.sem_id = '0;
      req_ch.thread_id = '0;
      req_ch.start_count = '0;
      rsp_ch.ready = 1'b0;
      calls_sent = 0;
      replies_seen = 0;
      fail_count = 0;
      stall_cycles = 0;
      real_items = 0;
      for (int i = 0; i < NSEM; i++) begin
         tbl_used[i] = 1'b0;
         tbl_count[i] = 0;
         tbl_head[i] = 0;
         tbl_fill[i] = 0;
      end
      for (int i = 0; i < CREATE_SPAN; i++)
         plan_used[i] = 1'b0;
      build_stimulus();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (queued_calls.size() != 0 || req_ch.valid)
         @(posedge clock);
      while (predicted_replies.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
